[rtl/core/tlps_pkg.sv]
// Package of the traffic light pedestrian sequencer: register indexes, reset values,
// the configuration and result records and the seven-segment decoder.
// Depends on nothing; tlps_cfg_regs, tlps_seq and the top level import it.
`default_nettype none

package tlps_pkg;

    localparam int CNT_W       = 24;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 24;

    localparam logic [CFG_INDEX_W-1:0] REG_GREEN_SECONDS   = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_YELLOW_SECONDS  = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_RED_SECONDS     = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ALL_RED_SECONDS = 8'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_COUNTDOWN_START = 8'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_SECOND_TICKS    = 8'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_SCAN_TICKS      = 8'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE_TICKS  = 8'd7;

    localparam logic [7:0]       RST_GREEN_SECONDS   = 8'd7;
    localparam logic [7:0]       RST_YELLOW_SECONDS  = 8'd3;
    localparam logic [7:0]       RST_RED_SECONDS     = 8'd9;
    localparam logic [7:0]       RST_ALL_RED_SECONDS = 8'd1;
    localparam logic [3:0]       RST_COUNTDOWN_START = 4'd9;
    localparam logic [CNT_W-1:0] RST_SECOND_TICKS    = 24'd1000000;
    localparam logic [CNT_W-1:0] RST_SCAN_TICKS      = 24'd100000;
    localparam logic [CNT_W-1:0] RST_DEBOUNCE_TICKS  = 24'd50000;

    localparam logic [3:0] DIGIT_MAX = 4'd9;
    localparam logic [6:0] SEG_BLANK = 7'h7F;

    localparam logic [2:0] CODE_GREEN     = 3'd0;
    localparam logic [2:0] CODE_YELLOW    = 3'd1;
    localparam logic [2:0] CODE_RED       = 3'd2;
    localparam logic [2:0] CODE_CLEAR_IN  = 3'd3;
    localparam logic [2:0] CODE_COUNT     = 3'd4;
    localparam logic [2:0] CODE_CLEAR_OUT = 3'd5;

    typedef enum logic [5:0] {
        PH_GREEN     = 6'b000001,
        PH_YELLOW    = 6'b000010,
        PH_RED       = 6'b000100,
        PH_CLEAR_IN  = 6'b001000,
        PH_COUNT     = 6'b010000,
        PH_CLEAR_OUT = 6'b100000
    } phase_t;

    typedef struct packed {
        logic [7:0]       green_seconds;
        logic [7:0]       yellow_seconds;
        logic [7:0]       red_seconds;
        logic [7:0]       all_red_seconds;
        logic [3:0]       countdown_start;
        logic [CNT_W-1:0] second_ticks;
        logic [CNT_W-1:0] scan_ticks;
        logic [CNT_W-1:0] debounce_ticks;
    } cfg_t;

    typedef struct packed {
        logic       red_lamp;
        logic       yellow_lamp;
        logic       green_lamp;
        logic [6:0] segments;
        logic       request_pending;
        logic [2:0] phase_code;
    } result_t;

    function automatic logic [7:0] at_least_one8(input logic [7:0] v);
        return (v == 8'd0) ? 8'd1 : v;
    endfunction

    function automatic logic [CNT_W-1:0] at_least_one_cnt(input logic [CNT_W-1:0] v);
        return (v == '0) ? CNT_W'(1) : v;
    endfunction

    function automatic logic [3:0] clamp_digit(input logic [3:0] v);
        return (v > DIGIT_MAX) ? DIGIT_MAX : v;
    endfunction

    // Active-low segments; digits above nine show as nine.
    function automatic logic [6:0] seg_decode(input logic [3:0] digit);
        logic [6:0] seg;
        case (digit)
            4'd0:    seg = 7'h40;
            4'd1:    seg = 7'h79;
            4'd2:    seg = 7'h24;
            4'd3:    seg = 7'h30;
            4'd4:    seg = 7'h19;
            4'd5:    seg = 7'h12;
            4'd6:    seg = 7'h02;
            4'd7:    seg = 7'h78;
            4'd8:    seg = 7'h00;
            default: seg = 7'h10;
        endcase
        return seg;
    endfunction

endpackage

`default_nettype wire

[rtl/core/tlps_tick_if.sv]
// Input channel of the sequencer: one item per time tick with the button level.
// Depends on nothing.
`default_nettype none

interface tlps_tick_if;
    logic valid;
    logic ready;
    logic button_level;

    modport source (output valid, output button_level, input ready);
    modport sink (input valid, input button_level, output ready);
endinterface

`default_nettype wire

[rtl/core/tlps_result_if.sv]
// Output channel of the sequencer: lamp drives, segments, request flag and phase code.
// Depends on nothing.
`default_nettype none

interface tlps_result_if;
    logic       valid;
    logic       ready;
    logic       red_lamp;
    logic       yellow_lamp;
    logic       green_lamp;
    logic [6:0] segments;
    logic       request_pending;
    logic [2:0] phase_code;

    modport source (
        output valid, output red_lamp, output yellow_lamp, output green_lamp,
        output segments, output request_pending, output phase_code, input ready
    );
    modport sink (
        input valid, input red_lamp, input yellow_lamp, input green_lamp,
        input segments, input request_pending, input phase_code, output ready
    );
endinterface

`default_nettype wire

[rtl/core/tlps_cfg_if.sv]
// Configuration write channel of the sequencer: register index and write data.
// Depends on nothing.
`default_nettype none

interface tlps_cfg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  index;
    logic [23:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[rtl/core/tlps_cfg_regs.sv]
// Configuration register bank of the sequencer, written through the configuration channel.
// Depends on tlps_pkg and tlps_cfg_if.
`default_nettype none

module tlps_cfg_regs
    import tlps_pkg::*;
#(
    parameter int TICK_COUNT_WIDTH = 24
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    tlps_cfg_if.sink    cfg,
    output cfg_t        cfg_values
);

    logic [7:0]                  green_reg;
    logic [7:0]                  yellow_reg;
    logic [7:0]                  red_reg;
    logic [7:0]                  all_red_reg;
    logic [3:0]                  start_reg;
    logic [TICK_COUNT_WIDTH-1:0] second_reg;
    logic [TICK_COUNT_WIDTH-1:0] scan_reg;
    logic [TICK_COUNT_WIDTH-1:0] debounce_reg;
    logic                        write_en;

    assign cfg.ready = 1'b1;
    assign write_en  = cfg.valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            green_reg    <= RST_GREEN_SECONDS;
            yellow_reg   <= RST_YELLOW_SECONDS;
            red_reg      <= RST_RED_SECONDS;
            all_red_reg  <= RST_ALL_RED_SECONDS;
            start_reg    <= RST_COUNTDOWN_START;
            second_reg   <= TICK_COUNT_WIDTH'(RST_SECOND_TICKS);
            scan_reg     <= TICK_COUNT_WIDTH'(RST_SCAN_TICKS);
            debounce_reg <= TICK_COUNT_WIDTH'(RST_DEBOUNCE_TICKS);
        end
        else if (write_en)
        begin
            case (cfg.index)
                REG_GREEN_SECONDS:   green_reg    <= cfg.data[7:0];
                REG_YELLOW_SECONDS:  yellow_reg   <= cfg.data[7:0];
                REG_RED_SECONDS:     red_reg      <= cfg.data[7:0];
                REG_ALL_RED_SECONDS: all_red_reg  <= cfg.data[7:0];
                REG_COUNTDOWN_START: start_reg    <= cfg.data[3:0];
                REG_SECOND_TICKS:    second_reg   <= TICK_COUNT_WIDTH'(cfg.data);
                REG_SCAN_TICKS:      scan_reg     <= TICK_COUNT_WIDTH'(cfg.data);
                REG_DEBOUNCE_TICKS:  debounce_reg <= TICK_COUNT_WIDTH'(cfg.data);
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        cfg_values.green_seconds   = green_reg;
        cfg_values.yellow_seconds  = yellow_reg;
        cfg_values.red_seconds     = red_reg;
        cfg_values.all_red_seconds = all_red_reg;
        cfg_values.countdown_start = start_reg;
        cfg_values.second_ticks    = CNT_W'(second_reg);
        cfg_values.scan_ticks      = CNT_W'(scan_reg);
        cfg_values.debounce_ticks  = CNT_W'(debounce_reg);
    end

endmodule

`default_nettype wire

[rtl/core/tlps_seq.sv]
// Phase sequencer, button scanning and debounce of the traffic light controller.
// Holds the sequencing state and advances it by one tick when step is high.
// Depends on tlps_pkg.
`default_nettype none

module tlps_seq
    import tlps_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic step,
    input  wire logic button_level,
    input  cfg_t      cfg_values,
    output result_t   tick_result
);

    phase_t           phase_reg,    phase_next;
    logic [CNT_W-1:0] tick_reg,     tick_next;
    logic [7:0]       sec_reg,      sec_next;
    logic [CNT_W-1:0] scan_reg,     scan_next;
    logic [CNT_W-1:0] deb_cnt_reg,  deb_cnt_next;
    logic             deb_wait_reg, deb_wait_next;
    logic             held_reg,     held_next;
    logic             req_reg,      req_next;
    logic [3:0]       digit_reg,    digit_next;

    logic             scanning;
    logic             confirm;
    logic             req_sampled;
    logic [CNT_W-1:0] deb_inc;
    logic [CNT_W-1:0] scan_inc;
    logic [CNT_W-1:0] tick_inc;
    logic [7:0]       sec_inc;
    logic [7:0]       phase_len;
    logic [3:0]       start_digit;
    logic             enter_en;
    phase_t           enter_phase;

    assign scanning    = (phase_reg == PH_GREEN) || (phase_reg == PH_YELLOW)
                         || (phase_reg == PH_RED);
    assign deb_inc     = deb_cnt_reg + CNT_W'(1);
    assign scan_inc    = scan_reg + CNT_W'(1);
    assign tick_inc    = tick_reg + CNT_W'(1);
    assign sec_inc     = sec_reg + 8'd1;
    assign start_digit = clamp_digit(cfg_values.countdown_start);

    always_comb
    begin
        case (phase_reg)
            PH_GREEN:  phase_len = at_least_one8(cfg_values.green_seconds);
            PH_YELLOW: phase_len = at_least_one8(cfg_values.yellow_seconds);
            PH_RED:    phase_len = at_least_one8(cfg_values.red_seconds);
            PH_COUNT:  phase_len = {4'd0, start_digit} + 8'd1;
            default:   phase_len = at_least_one8(cfg_values.all_red_seconds);
        endcase
    end

    always_comb
    begin
        phase_next    = phase_reg;
        tick_next     = tick_reg;
        sec_next      = sec_reg;
        scan_next     = scan_reg;
        deb_cnt_next  = deb_cnt_reg;
        deb_wait_next = deb_wait_reg;
        held_next     = held_reg;
        req_next      = req_reg;
        digit_next    = digit_reg;
        confirm       = 1'b0;
        enter_en      = 1'b0;

        // Button sampling and debounce.
        if (deb_wait_reg)
        begin
            deb_cnt_next = deb_inc;
            if (deb_inc >= cfg_values.debounce_ticks)
            begin
                deb_wait_next = 1'b0;
                confirm       = 1'b1;
            end
        end
        else if (scanning && (scan_reg == '0))
        begin
            if (button_level)
            begin
                held_next = 1'b0;
            end
            else if (cfg_values.debounce_ticks == '0)
            begin
                confirm = 1'b1;
            end
            else
            begin
                deb_wait_next = 1'b1;
                deb_cnt_next  = '0;
            end
        end

        if (confirm && !button_level && !held_reg)
        begin
            held_next = 1'b1;
            req_next  = 1'b1;
        end
        req_sampled = req_next;

        if (scanning)
        begin
            scan_next = (scan_inc >= at_least_one_cnt(cfg_values.scan_ticks)) ? '0 : scan_inc;
        end

        // Second timing and phase changes.
        tick_next = tick_inc;
        if (tick_inc >= at_least_one_cnt(cfg_values.second_ticks))
        begin
            tick_next = '0;
            sec_next  = sec_inc;
            if ((phase_reg == PH_COUNT) && (digit_reg != 4'd0))
            begin
                digit_next = digit_reg - 4'd1;
            end
            enter_en = (sec_inc >= phase_len);
        end

        case (phase_reg)
            PH_GREEN:    enter_phase = PH_YELLOW;
            PH_YELLOW:   enter_phase = req_sampled ? PH_CLEAR_IN : PH_RED;
            PH_RED:      enter_phase = PH_GREEN;
            PH_CLEAR_IN: enter_phase = PH_COUNT;
            PH_COUNT:    enter_phase = PH_CLEAR_OUT;
            default:     enter_phase = PH_GREEN;
        endcase

        if (enter_en)
        begin
            phase_next = enter_phase;
            sec_next   = 8'd0;
            scan_next  = '0;
            if (phase_reg == PH_CLEAR_OUT)
            begin
                req_next = 1'b0;
            end
            if (enter_phase == PH_CLEAR_IN)
            begin
                deb_wait_next = 1'b0;
                deb_cnt_next  = '0;
            end
            if (enter_phase == PH_COUNT)
            begin
                digit_next = start_digit;
            end
        end
    end

    always_comb
    begin
        tick_result.red_lamp        = 1'b0;
        tick_result.yellow_lamp     = 1'b0;
        tick_result.green_lamp      = 1'b0;
        tick_result.segments        = SEG_BLANK;
        tick_result.request_pending = req_sampled;
        case (phase_reg)
            PH_GREEN:
            begin
                tick_result.green_lamp = 1'b1;
                tick_result.phase_code = CODE_GREEN;
            end
            PH_YELLOW:
            begin
                tick_result.yellow_lamp = 1'b1;
                tick_result.phase_code  = CODE_YELLOW;
            end
            PH_RED:
            begin
                tick_result.red_lamp   = 1'b1;
                tick_result.phase_code = CODE_RED;
            end
            PH_CLEAR_IN:
            begin
                tick_result.red_lamp   = 1'b1;
                tick_result.phase_code = CODE_CLEAR_IN;
            end
            PH_COUNT:
            begin
                tick_result.red_lamp   = 1'b1;
                tick_result.segments   = seg_decode(digit_reg);
                tick_result.phase_code = CODE_COUNT;
            end
            default:
            begin
                tick_result.red_lamp   = 1'b1;
                tick_result.phase_code = CODE_CLEAR_OUT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_GREEN;
            tick_reg     <= '0;
            sec_reg      <= 8'd0;
            scan_reg     <= '0;
            deb_cnt_reg  <= '0;
            deb_wait_reg <= 1'b0;
            held_reg     <= 1'b0;
            req_reg      <= 1'b0;
            digit_reg    <= 4'd0;
        end
        else if (step)
        begin
            phase_reg    <= phase_next;
            tick_reg     <= tick_next;
            sec_reg      <= sec_next;
            scan_reg     <= scan_next;
            deb_cnt_reg  <= deb_cnt_next;
            deb_wait_reg <= deb_wait_next;
            held_reg     <= held_next;
            req_reg      <= req_next;
            digit_reg    <= digit_next;
        end
    end

    // No debounce wait may survive outside the scanning phases.
    assert property (@(posedge clk) disable iff (!rst_n) !scanning |-> !deb_wait_reg)
        else $error("debounce wait active outside scanning phases");

    // The pedestrian crossing is only ever entered with a request latched.
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_CLEAR_IN || phase_reg == PH_COUNT || phase_reg == PH_CLEAR_OUT)
        |-> req_reg)
        else $error("crossing phase without a latched request");

    // A request is only dropped when the closing all-red ends.
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(req_reg) |-> ($past(phase_reg) == PH_CLEAR_OUT) && (phase_reg == PH_GREEN))
        else $error("request cleared outside the end of the crossing");

    // The countdown digit never leaves the decimal range.
    assert property (@(posedge clk) disable iff (!rst_n) digit_reg <= DIGIT_MAX)
        else $error("countdown digit out of range");

endmodule

`default_nettype wire

[rtl/core/traffic_light_pedestrian_sequencer.sv]
// Top level of the traffic light pedestrian sequencer: input register, result register,
// configuration bank and phase sequencer.
// Depends on tlps_pkg, the three channel interfaces, tlps_cfg_regs and tlps_seq.
//
// Usage: each item on the tick channel is one time tick carrying the active-low
// pedestrian button level. For every item exactly one result item is produced on the
// result channel, giving the lamp drives, the active-low countdown segments, the
// request flag and the phase code of the tick it belongs to.
// The tick is held in an input register; when the output register can load, the sequencer
// state advances and the result is captured in the output register. One item is taken
// every cycle while the receiver keeps taking results.
// When the receiver stalls, the result stays in the output register and the input
// register fills; ticks are then refused until the result is taken.
// Configuration registers are written through the configuration channel, which is
// always ready; writes belong in idle periods only. Unknown indexes are ignored.
// Reset puts the sequencer in green with all counters and the request cleared and
// loads the default phase and timing values.
`default_nettype none

module traffic_light_pedestrian_sequencer
    import tlps_pkg::*;
#(
    parameter int TICK_COUNT_WIDTH = 24
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    tlps_tick_if.sink     tick,
    tlps_result_if.source result,
    tlps_cfg_if.sink      cfg
);

    cfg_t    cfg_values;
    result_t tick_result;
    result_t out_reg;
    logic    in_valid_reg;
    logic    in_level_reg;
    logic    out_valid_reg;
    logic    out_load;
    logic    s1_fire;
    logic    in_take;

    tlps_cfg_regs #(
        .TICK_COUNT_WIDTH (TICK_COUNT_WIDTH)
    ) u_cfg_regs (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .cfg_values (cfg_values)
    );

    tlps_seq u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (s1_fire),
        .button_level (in_level_reg),
        .cfg_values   (cfg_values),
        .tick_result  (tick_result)
    );

    assign out_load   = !out_valid_reg || result.ready;
    assign s1_fire    = in_valid_reg && out_load;
    assign tick.ready = !in_valid_reg || out_load;
    assign in_take    = tick.valid && tick.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (s1_fire)
            begin
                in_valid_reg <= 1'b0;
            end

            if (s1_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_level_reg <= tick.button_level;
        end
        if (s1_fire)
        begin
            out_reg <= tick_result;
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.red_lamp        = out_reg.red_lamp;
    assign result.yellow_lamp     = out_reg.yellow_lamp;
    assign result.green_lamp      = out_reg.green_lamp;
    assign result.segments        = out_reg.segments;
    assign result.request_pending = out_reg.request_pending;
    assign result.phase_code      = out_reg.phase_code;

    // An item held in the input register is passed on as soon as the output can load.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && out_load && !in_take) |=> !in_valid_reg)
        else $error("input item not passed on to the result register");

    // A stalled result blocks a new item from entering the full input register.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && out_valid_reg && !result.ready) |-> !tick.ready)
        else $error("tick accepted while both stages are full");

    // A result becomes valid only in the cycle after an item left the input register.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(in_valid_reg))
        else $error("result raised without a pending item");

endmodule

`default_nettype wire
